/* hdl/sorted_array_binary_search_core_assert.svh */
// ----------------------------------------------------------------------------
// sorted array binary search core assertion macros
// Property macros for the core; they expand to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_BINARY_SEARCH_CORE_ASSERT_SVH
`define SORTED_ARRAY_BINARY_SEARCH_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define SABS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sabs assertion failed");
// next-cycle implication
`define SABS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sabs assertion failed");
`else
`define SABS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SABS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/sabs_pkg.sv */
// ----------------------------------------------------------------------------
// sabs_pkg
// Types and constants shared by the sorted array binary search core.
// ----------------------------------------------------------------------------
package sabs_pkg;

	localparam int DEPTH_DEF      = 1024;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int INDEX_W   = 10;
	localparam int VALUE_W   = 32;
	localparam int POS_W     = 10;
	localparam int LEN_W     = 11;
	localparam int MODE_W    = 2;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;

	typedef logic [MODE_W-1:0]    mode_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam mode_t MODE_EXACT     = 2'd0;
	localparam mode_t MODE_LAST_ONE  = 2'd1;
	localparam mode_t MODE_FIRST_ONE = 2'd2;

	localparam cfg_idx_t REG_ARRAY_LENGTH = 1'd0;
	localparam cfg_idx_t REG_SEARCH_MODE  = 1'd1;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	typedef struct packed {
		logic                      command;
		logic [INDEX_W-1:0]        index;
		logic signed [VALUE_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROBE,
		S_DONE
	} state_t;

endpackage

/* hdl/sorted_array_binary_search_core.sv */
// ----------------------------------------------------------------------------
// sorted array binary search core
// Word store loaded by write items, searched by one of three binary searches.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | in_data (command, index, value)
//  out     | output    | out_valid / out_stall | out_data (found, position)
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
//  a write item is taken while idle; a search runs its memory probes one after another,
//  then a result state and a return to idle.
//  the single read port of the store sets the pace: one probe per cycle.
//  reset clears control state and the configuration registers; the store and the datapath registers are not cleared.
//  in_stall is high while a search runs; a stalled output holds its result
//  and the finished search waits in its result stage until the register frees.
// ----------------------------------------------------------------------------
`include "sorted_array_binary_search_core_assert.svh"

module sorted_array_binary_search_core #(
	parameter int DEPTH      = sabs_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = sabs_pkg::DATA_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  sabs_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output sabs_pkg::out_item_t        out_data,
	input  logic                       cfg_we,
	input  sabs_pkg::cfg_idx_t         cfg_index,
	input  logic [sabs_pkg::CFG_W-1:0] cfg_data
);
	import sabs_pkg::*;

	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DEP_BW = ($clog2(DEPTH + 1) > LEN_W) ? $clog2(DEPTH + 1) : LEN_W;
	localparam int CW     = DEP_BW + 1;
	localparam logic signed [CW-1:0] ONE = CW'(1);

	// store
	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;
	logic                  mem_we;
	logic [AW-1:0]         mem_addr;
	logic [DATA_WIDTH-1:0] mem_wdata;

	// configuration
	logic [LEN_W-1:0] length_q;
	mode_t            mode_q;

	// search state
	state_t                  state_q, state_d;
	logic signed [CW-1:0]    head_q, tail_q, mid_q;
	logic [DATA_WIDTH-1:0]   key_q;
	logic                    res_found_q;
	logic [POS_W-1:0]        res_pos_q;
	logic                    out_valid_q;
	out_item_t               out_q;

	logic                 in_xfer, write_xfer, search_xfer, out_free;
	logic signed [CW-1:0] n, head_sel, tail_sel, mid_next;
	logic signed [CW:0]   mid_sum;
	logic                 hit, below, go, fin, fin_found, idx_ok;
	logic [POS_W-1:0]     fin_pos;

	assign in_xfer     = in_valid && !in_stall;
	assign write_xfer  = in_xfer && (in_data.command == CMD_WRITE);
	assign search_xfer = in_xfer && (in_data.command == CMD_SEARCH);
	assign out_free    = !out_valid_q || !out_stall;
	assign idx_ok      = (32'(in_data.index) < 32'(DEPTH));

	// search length saturates at the store depth
	assign n = (CW'(length_q) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(length_q);

	// probe evaluation and next bounds
	always_comb begin
		hit      = 1'b0;
		below    = 1'b0;
		head_sel = head_q;
		tail_sel = tail_q;
		if (state_q == S_PROBE) begin
			if (mode_q == MODE_EXACT) begin
				hit   = (rdata_q == key_q);
				below = ($signed(rdata_q) < $signed(key_q));
				if (below) begin
					head_sel = mid_q + ONE;
				end else begin
					tail_sel = mid_q - ONE;
				end
			end else if (mode_q == MODE_LAST_ONE) begin
				hit = (rdata_q == DATA_WIDTH'(1));
				if (hit) begin
					head_sel = mid_q;
				end else begin
					tail_sel = mid_q - ONE;
				end
			end else begin
				hit = (rdata_q == DATA_WIDTH'(1));
				if (hit) begin
					tail_sel = mid_q;
				end else begin
					head_sel = mid_q + ONE;
				end
			end
		end else begin
			// starting bounds
			case (mode_q)
				MODE_EXACT: begin
					head_sel = '0;
					tail_sel = n - ONE;
				end
				MODE_LAST_ONE: begin
					head_sel = -ONE;
					tail_sel = n - ONE;
				end
				default: begin
					head_sel = '0;
					tail_sel = n;
				end
			endcase
		end

		// ceil midpoint for the last-one search
		mid_sum  = {head_sel[CW-1], head_sel} + {tail_sel[CW-1], tail_sel}
			+ {{CW{1'b0}}, (mode_q == MODE_LAST_ONE)};
		mid_next = mid_sum[CW:1];

		case (mode_q)
			MODE_EXACT:     go = (head_sel <= tail_sel);
			MODE_LAST_ONE:  go = (head_sel < tail_sel);
			MODE_FIRST_ONE: go = (head_sel < tail_sel);
			default:        go = 1'b0;
		endcase

		if ((state_q == S_PROBE) && (mode_q == MODE_EXACT) && hit) begin
			fin       = 1'b1;
			fin_found = 1'b1;
			fin_pos   = POS_W'($unsigned(mid_q));
		end else begin
			fin       = !go;
			fin_found = ((mode_q == MODE_LAST_ONE) && !head_sel[CW-1])
				|| ((mode_q == MODE_FIRST_ONE) && (head_sel != n));
			fin_pos   = fin_found ? POS_W'($unsigned(head_sel)) : '0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (search_xfer) begin
					state_d = fin ? S_DONE : S_PROBE;
				end
			end
			S_PROBE: begin
				if (fin) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall  = (state_q != S_IDLE);
		mem_we    = write_xfer && idx_ok;
		mem_addr  = write_xfer ? AW'(in_data.index) : mid_next[AW-1:0];
		mem_wdata = DATA_WIDTH'($unsigned(in_data.value));
		out_valid = out_valid_q;
		out_data  = out_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end
		rdata_q <= mem_q[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			length_q    <= '0;
			mode_q      <= MODE_EXACT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_ARRAY_LENGTH: length_q <= cfg_data[LEN_W-1:0];
					REG_SEARCH_MODE:  mode_q   <= cfg_data[MODE_W-1:0];
					default: ;
				endcase
			end
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (search_xfer) begin
			key_q <= DATA_WIDTH'($unsigned(in_data.value));
		end
		if (search_xfer || (state_q == S_PROBE)) begin
			head_q <= head_sel;
			tail_q <= tail_sel;
			mid_q  <= mid_next;
			if (fin) begin
				res_found_q <= fin_found;
				res_pos_q   <= fin_pos;
			end
		end
		if ((state_q == S_DONE) && out_free) begin
			out_q.found    <= res_found_q;
			out_q.position <= res_pos_q;
		end
	end

	`SABS_ASSERT_NXT(a_search_busy, clk, arst_n, search_xfer, state_q != S_IDLE)
	`SABS_ASSERT_IMP(a_probe_in_range, clk, arst_n, state_q == S_PROBE, (mid_q >= 0) && (mid_q < n))
	`SABS_ASSERT_IMP(a_out_from_done, clk, arst_n, $rose(out_valid_q), $past(state_q == S_DONE))
	`SABS_ASSERT_IMP(a_miss_pos_zero, clk, arst_n, out_valid && !out_data.found, out_data.position == '0)

endmodule
